>>> rtl/core/tfgp_pkg.sv
// Shared types, constants and arithmetic helpers of the turn fillet guide point block.
package tfgp_pkg;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int SPACING_W = 31;
  localparam int CFG_W = 31;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAND     = 3'd1;
  localparam logic [2:0] ST_PARALLEL = 3'd2;
  localparam logic [2:0] ST_BEHIND   = 3'd3;

  localparam logic [1:0] REG_MIN_DEFL = 2'd0;
  localparam logic [1:0] REG_MAX_DEFL = 2'd1;
  localparam logic [1:0] REG_SPACING  = 2'd2;
  localparam logic [1:0] REG_LEN_TOL  = 2'd3;

  localparam logic [ANGLE_W-1:0]   RST_MIN_DEFL = 16'd1820;
  localparam logic [ANGLE_W-1:0]   RST_MAX_DEFL = 16'd30948;
  localparam logic [SPACING_W-1:0] RST_SPACING  = 31'd32768;
  localparam logic [15:0]          RST_LEN_TOL  = 16'd66;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic signed [33:0] CORDIC_ONE  = 34'sd1073741824;
  localparam logic [4:0] CORDIC_LAST = 5'd29;
  localparam logic [5:0] DIV_LAST    = 6'd62;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic [ANGLE_W-1:0]        start_heading;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [ANGLE_W-1:0]        end_heading;
  } tfgp_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [ANGLE_W-1:0]        point_heading;
    logic                      valid_res;
    logic [2:0]                status;
    logic                      last;
  } tfgp_out_t;

  typedef struct packed {
    tfgp_in_t           item;
    logic               band_rej;
    logic [ANGLE_W-1:0] dwrap;
    logic [ANGLE_W-1:0] defl;
  } tfgp_entry_t;

  typedef struct packed {
    logic               done;
    logic signed [29:0] cos_v;
    logic signed [29:0] sin_v;
  } tfgp_trig_t;

  typedef struct packed {
    logic        done;
    logic [62:0] quo;
  } tfgp_quo_t;

  function automatic logic signed [31:0] step_angle(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004757;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      5'd24: v = 32'sd41;
      5'd25: v = 32'sd20;
      5'd26: v = 32'sd10;
      5'd27: v = 32'sd5;
      5'd28: v = 32'sd3;
      5'd29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Rounds a Q28 product back to Q16, half up.
  function automatic logic signed [37:0] round28(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = p + 66'sd134217728;
    return s[65:28];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [37:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tfgp_queue.sv
// Two-entry item queue between the front and the back of the block.
module tfgp_queue import tfgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  tfgp_entry_t push_data,
  input  logic        pop,
  output logic        full,
  output logic        empty,
  output tfgp_entry_t head
);

  tfgp_entry_t mem_r [QUEUE_DEPTH];
  logic        wr_r;
  logic        rd_r;
  logic [1:0]  cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/tfgp_front.sv
// Front end: accepts an item, wraps the turn angle and checks the deflection band.
module tfgp_front import tfgp_pkg::*; (
  input  logic               start,
  input  tfgp_in_t           in_data,
  input  logic               q_full,
  input  logic [ANGLE_W-1:0] min_deflection,
  input  logic [ANGLE_W-1:0] max_deflection,
  output logic               push,
  output tfgp_entry_t        entry
);

  logic [ANGLE_W-1:0] dwrap;
  logic [ANGLE_W-1:0] defl;

  always_comb begin
    dwrap = in_data.end_heading - in_data.start_heading;
    defl  = dwrap[ANGLE_W-1] ? (16'd0 - dwrap) : dwrap;
    push  = start & ~q_full;
    entry.item     = in_data;
    entry.dwrap    = dwrap;
    entry.defl     = defl;
    entry.band_rej = (defl < min_deflection) || (defl > max_deflection);
  end

endmodule

>>> rtl/core/tfgp_cordic.sv
// Iterative 30-step CORDIC giving cosine and sine of a 32-bit binary angle in Q28.
module tfgp_cordic import tfgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] angle,
  output tfgp_trig_t  res
);

  logic signed [33:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [1:0]         quad_r;
  logic [4:0]         i_r;
  logic               run_r;
  logic               done_r;

  logic [31:0]        shifted;
  logic signed [31:0] z0;
  logic signed [33:0] xs, ys, c_pre, s_pre;
  logic signed [34:0] c_rnd, s_rnd;

  always_comb begin
    shifted = angle + 32'h2000_0000;
    z0 = $signed({2'b00, shifted[29:0]}) - 32'sh2000_0000;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    case (quad_r)
      2'd0: begin c_pre = x_r;  s_pre = y_r;  end
      2'd1: begin c_pre = -y_r; s_pre = x_r;  end
      2'd2: begin c_pre = -x_r; s_pre = -y_r; end
      default: begin c_pre = y_r; s_pre = -x_r; end
    endcase
    c_rnd = {c_pre[33], c_pre} + 35'sd2;
    s_rnd = {s_pre[33], s_pre} + 35'sd2;
    res.done  = done_r;
    res.cos_v = c_rnd[31:2];
    res.sin_v = s_rnd[31:2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quad_r <= shifted[31:30];
        z_r    <= z0;
        y_r    <= 34'sd0;
        i_r    <= 5'd0;
        if (z0 == 32'sd0) begin
          x_r    <= CORDIC_ONE;
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          x_r   <= CORDIC_GAIN;
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        if (!z_r[31]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - step_angle(i_r);
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + step_angle(i_r);
        end
        i_r <= i_r + 5'd1;
        if (i_r == CORDIC_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/tfgp_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module tfgp_div import tfgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [62:0] num,
  input  logic [28:0] den,
  output tfgp_quo_t   res
);

  logic [62:0] q_r;
  logic [29:0] rem_r;
  logic [28:0] den_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        done_r;

  logic [30:0] rem_sh;
  logic [30:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, q_r[62]};
    diff   = rem_sh - {2'b00, den_r};
    ge     = (rem_sh >= {2'b00, den_r});
    res.done = done_r;
    res.quo  = q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= num;
        rem_r <= 30'd0;
        den_r <= den;
        cnt_r <= 6'd0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (ge) begin
          rem_r <= diff[29:0];
          q_r   <= {q_r[61:0], 1'b1};
        end else begin
          rem_r <= rem_sh[29:0];
          q_r   <= {q_r[61:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/tfgp_back.sv
// Back end: sequences trig, division and products for one item and emits its results.
module tfgp_back import tfgp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  tfgp_entry_t          q_head,
  output logic                 q_pop,
  input  logic [SPACING_W-1:0] min_guide_spacing,
  input  logic [15:0]          length_tolerance,
  output logic                 cor_start,
  output logic [31:0]          cor_angle,
  input  tfgp_trig_t           cor_res,
  output logic                 div_start,
  output logic [62:0]          div_num,
  output logic [28:0]          div_den,
  input  tfgp_quo_t            div_res,
  output logic                 out_valid,
  output tfgp_out_t            out_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_W_DET, S_W_D1, S_W_D2, S_W_Q, S_W_B,
    S_MT1, S_MT2, S_MT3, S_WT, S_MU2, S_MU3, S_WU, S_CHK_TU,
    S_MC2, S_MC3, S_WTAN, S_MR1, S_MR2, S_MA1, S_MA2, S_MA3,
    S_ME1, S_ME2, S_MX1, S_MX2, S_EMIT_E, S_EMIT_A, S_EMIT_X
  } state_t;

  state_t state_r;

  logic signed [COORD_W-1:0] ax_r, ay_r;
  logic [ANGLE_W-1:0] ha_r, hb_r, dwrap_r, defl_r;
  logic band_r;
  logic signed [32:0] rx_r, ry_r;
  logic signed [29:0] det_r, c1_r, s1_r, c2_r, s2_r, cq_r, sq_r, bc_r, bs_r, tanq_r;
  logic signed [65:0] acc_r, prod_r;
  logic div_neg_r;
  logic signed [34:0] t_r, u_r, leg_r, reach_r;
  logic signed [37:0] cx_r, cy_r, apx_r, apy_r, enx_r, eny_r, exx_r, exy_r;
  logic out_valid_r;
  tfgp_out_t out_r;

  logic signed [35:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [65:0] num_s, num_abs;
  logic signed [29:0] den_s, den_abs;
  logic [33:0] q_cl;
  logic signed [34:0] len_q;
  logic signed [29:0] tan_q;
  logic signed [37:0] rnd;
  logic signed [ANGLE_W-1:0] delta;
  logic [17:0] m18;
  logic [16:0] h17;
  logic [31:0] b32;
  logic signed [35:0] t_surplus, u_surplus, spacing_s;
  logic entry_ok, exit_ok, tu_bad;

  always_comb begin
    delta = $signed(dwrap_r);
    m18 = {2'b00, ha_r} + {2'b00, ha_r} + {{2{delta[ANGLE_W-1]}}, delta};
    h17 = m18[16:0] + 17'd1;
    b32 = {m18[16:0], 15'd0} + ((delta > 16'sd0) ? 32'h4000_0000 : 32'hC000_0000);

    mul_a = 36'sd0;
    mul_b = 30'sd0;
    case (state_r)
      S_MT1:    begin mul_a = 36'(rx_r);    mul_b = s2_r;   end
      S_MT2:    begin mul_a = 36'(ry_r);    mul_b = c2_r;   end
      S_WT:     begin mul_a = 36'(ry_r);    mul_b = c1_r;   end
      S_MU2:    begin mul_a = 36'(rx_r);    mul_b = s1_r;   end
      S_CHK_TU: begin mul_a = 36'(t_r);     mul_b = c1_r;   end
      S_MC2:    begin mul_a = 36'(t_r);     mul_b = s1_r;   end
      S_MR1:    begin mul_a = 36'(leg_r);   mul_b = tanq_r; end
      S_MA1:    begin mul_a = 36'(reach_r); mul_b = bc_r;   end
      S_MA2:    begin mul_a = 36'(reach_r); mul_b = bs_r;   end
      S_MA3:    begin mul_a = 36'(leg_r);   mul_b = c1_r;   end
      S_ME1:    begin mul_a = 36'(leg_r);   mul_b = s1_r;   end
      S_ME2:    begin mul_a = 36'(leg_r);   mul_b = c2_r;   end
      S_MX1:    begin mul_a = 36'(leg_r);   mul_b = s2_r;   end
      default:  begin mul_a = 36'sd0;       mul_b = 30'sd0; end
    endcase

    case (state_r)
      S_MT3, S_MU3: num_s = acc_r - prod_r;
      S_MC3:        num_s = {{8{sq_r[29]}}, sq_r, 28'd0};
      default:      num_s = 66'sd0;
    endcase
    num_abs = num_s[65] ? -num_s : num_s;
    den_s   = (state_r == S_MC3) ? cq_r : det_r;
    den_abs = den_s[29] ? -den_s : den_s;
    div_num = num_abs[62:0];
    div_den = den_abs[28:0];
    div_start = (state_r == S_MT3) || (state_r == S_MU3) || (state_r == S_MC3);

    q_cl  = (div_res.quo > 63'h2_0000_0000) ? 34'h2_0000_0000 : div_res.quo[33:0];
    len_q = div_neg_r ? -$signed({1'b0, q_cl}) : $signed({1'b0, q_cl});
    tan_q = div_neg_r ? -$signed(div_res.quo[29:0]) : $signed(div_res.quo[29:0]);
    rnd   = round28(prod_r);

    cor_start = 1'b0;
    cor_angle = {dwrap_r, 16'd0};
    case (state_r)
      S_CHECK: begin
        cor_start = ~band_r;
        cor_angle = {dwrap_r, 16'd0};
      end
      S_W_DET: begin
        cor_start = cor_res.done && (cor_res.sin_v != 30'sd0);
        cor_angle = {ha_r, 16'd0};
      end
      S_W_D1: begin
        cor_start = cor_res.done;
        cor_angle = {hb_r, 16'd0};
      end
      S_W_D2: begin
        cor_start = cor_res.done;
        cor_angle = {2'b00, defl_r, 14'd0};
      end
      S_W_Q: begin
        cor_start = cor_res.done;
        cor_angle = b32;
      end
      default: begin
        cor_start = 1'b0;
        cor_angle = {dwrap_r, 16'd0};
      end
    endcase

    tu_bad = (t_r <= $signed({19'd0, length_tolerance})) ||
             (u_r <= $signed({19'd0, length_tolerance}));
    t_surplus = 36'(t_r) - 36'(leg_r);
    u_surplus = 36'(u_r) - 36'(leg_r);
    spacing_s = $signed({5'd0, min_guide_spacing});
    entry_ok  = t_surplus > spacing_s;
    exit_ok   = u_surplus > spacing_s;

    q_pop = (state_r == S_IDLE) && !q_empty;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (div_start) begin
      div_neg_r <= num_s[65] ^ den_s[29];
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            ax_r    <= q_head.item.start_x;
            ay_r    <= q_head.item.start_y;
            ha_r    <= q_head.item.start_heading;
            hb_r    <= q_head.item.end_heading;
            dwrap_r <= q_head.dwrap;
            defl_r  <= q_head.defl;
            band_r  <= q_head.band_rej;
            rx_r    <= 33'(q_head.item.end_x) - 33'(q_head.item.start_x);
            ry_r    <= 33'(q_head.item.end_y) - 33'(q_head.item.start_y);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (band_r) begin
            out_valid_r <= 1'b1;
            out_r       <= '{point_x: '0, point_y: '0, point_heading: '0,
                             valid_res: 1'b0, status: ST_BAND, last: 1'b1};
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_W_DET;
          end
        end
        S_W_DET: begin
          if (cor_res.done) begin
            det_r <= cor_res.sin_v;
            if (cor_res.sin_v == 30'sd0) begin
              out_valid_r <= 1'b1;
              out_r       <= '{point_x: '0, point_y: '0, point_heading: '0,
                               valid_res: 1'b0, status: ST_PARALLEL, last: 1'b1};
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_W_D1;
            end
          end
        end
        S_W_D1: begin
          if (cor_res.done) begin
            c1_r    <= cor_res.cos_v;
            s1_r    <= cor_res.sin_v;
            state_r <= S_W_D2;
          end
        end
        S_W_D2: begin
          if (cor_res.done) begin
            c2_r    <= cor_res.cos_v;
            s2_r    <= cor_res.sin_v;
            state_r <= S_W_Q;
          end
        end
        S_W_Q: begin
          if (cor_res.done) begin
            cq_r    <= cor_res.cos_v;
            sq_r    <= cor_res.sin_v;
            state_r <= S_W_B;
          end
        end
        S_W_B: begin
          if (cor_res.done) begin
            bc_r    <= cor_res.cos_v;
            bs_r    <= cor_res.sin_v;
            state_r <= S_MT1;
          end
        end
        S_MT1: state_r <= S_MT2;
        S_MT2: begin
          acc_r   <= prod_r;
          state_r <= S_MT3;
        end
        S_MT3: state_r <= S_WT;
        S_WT: begin
          if (div_res.done) begin
            t_r     <= len_q;
            state_r <= S_MU2;
          end
        end
        S_MU2: begin
          acc_r   <= prod_r;
          state_r <= S_MU3;
        end
        S_MU3: state_r <= S_WU;
        S_WU: begin
          if (div_res.done) begin
            u_r     <= len_q;
            state_r <= S_CHK_TU;
          end
        end
        S_CHK_TU: begin
          if (tu_bad) begin
            out_valid_r <= 1'b1;
            out_r       <= '{point_x: '0, point_y: '0, point_heading: '0,
                             valid_res: 1'b0, status: ST_BEHIND, last: 1'b1};
            state_r     <= S_IDLE;
          end else begin
            leg_r   <= (t_r < u_r) ? t_r : u_r;
            state_r <= S_MC2;
          end
        end
        S_MC2: begin
          cx_r    <= 38'(ax_r) + rnd;
          state_r <= S_MC3;
        end
        S_MC3: begin
          cy_r    <= 38'(ay_r) + rnd;
          state_r <= S_WTAN;
        end
        S_WTAN: begin
          if (div_res.done) begin
            tanq_r  <= tan_q;
            state_r <= S_MR1;
          end
        end
        S_MR1: state_r <= S_MR2;
        S_MR2: begin
          reach_r <= rnd[34:0];
          state_r <= S_MA1;
        end
        S_MA1: state_r <= S_MA2;
        S_MA2: begin
          apx_r   <= cx_r + rnd;
          state_r <= S_MA3;
        end
        S_MA3: begin
          apy_r   <= cy_r + rnd;
          state_r <= S_ME1;
        end
        S_ME1: begin
          enx_r   <= cx_r - rnd;
          state_r <= S_ME2;
        end
        S_ME2: begin
          eny_r   <= cy_r - rnd;
          state_r <= S_MX1;
        end
        S_MX1: begin
          exx_r   <= cx_r + rnd;
          state_r <= S_MX2;
        end
        S_MX2: begin
          exy_r   <= cy_r + rnd;
          state_r <= S_EMIT_E;
        end
        S_EMIT_E: begin
          if (entry_ok) begin
            out_valid_r <= 1'b1;
            out_r       <= '{point_x: sat_coord(enx_r), point_y: sat_coord(eny_r),
                             point_heading: ha_r, valid_res: 1'b1,
                             status: ST_OK, last: 1'b0};
          end
          state_r <= S_EMIT_A;
        end
        S_EMIT_A: begin
          out_valid_r <= 1'b1;
          out_r       <= '{point_x: sat_coord(apx_r), point_y: sat_coord(apy_r),
                           point_heading: h17[16:1], valid_res: 1'b1,
                           status: ST_OK, last: ~exit_ok};
          state_r     <= exit_ok ? S_EMIT_X : S_IDLE;
        end
        S_EMIT_X: begin
          out_valid_r <= 1'b1;
          out_r       <= '{point_x: sat_coord(exx_r), point_y: sat_coord(exy_r),
                           point_heading: hb_r, valid_res: 1'b1,
                           status: ST_OK, last: 1'b1};
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/turn_fillet_guide_points.sv
// Top level of the turn fillet guide point block: configuration, front, queue and back.
// Five CORDIC runs and three divisions, with sequencing and the multiplier, lie between
// accepting an item and its last result; the single back end takes a new item only once
// it is through with the last one, and the queue holds two. A rejected item leaves with
// a single final result carrying its status; the receiver cannot stall results.
// Synchronous reset empties the queue, idles the back end and restores register defaults.
module turn_fillet_guide_points import tfgp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  tfgp_in_t         in_data,
  output logic             out_valid,
  output tfgp_out_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [ANGLE_W-1:0]   min_defl_r, max_defl_r;
  logic [SPACING_W-1:0] spacing_r;
  logic [15:0]          len_tol_r;

  logic        q_full, q_empty, q_push, q_pop;
  tfgp_entry_t q_in, q_head;
  logic        cor_start, div_start;
  logic [31:0] cor_angle;
  tfgp_trig_t  cor_res;
  logic [62:0] div_num;
  logic [28:0] div_den;
  tfgp_quo_t   div_res;

  assign busy = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_defl_r <= RST_MIN_DEFL;
      max_defl_r <= RST_MAX_DEFL;
      spacing_r  <= RST_SPACING;
      len_tol_r  <= RST_LEN_TOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_DEFL: min_defl_r <= cfg_wdata[ANGLE_W-1:0];
        REG_MAX_DEFL: max_defl_r <= cfg_wdata[ANGLE_W-1:0];
        REG_SPACING:  spacing_r  <= cfg_wdata[SPACING_W-1:0];
        REG_LEN_TOL:  len_tol_r  <= cfg_wdata[15:0];
        default:      len_tol_r  <= len_tol_r;
      endcase
    end
  end

  tfgp_front u_front (
    .start          (start),
    .in_data        (in_data),
    .q_full         (q_full),
    .min_deflection (min_defl_r),
    .max_deflection (max_defl_r),
    .push           (q_push),
    .entry          (q_in)
  );

  tfgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  tfgp_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .res   (cor_res)
  );

  tfgp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  tfgp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .min_guide_spacing (spacing_r),
    .length_tolerance  (len_tol_r),
    .cor_start         (cor_start),
    .cor_angle         (cor_angle),
    .cor_res           (cor_res),
    .div_start         (div_start),
    .div_num           (div_num),
    .div_den           (div_den),
    .div_res           (div_res),
    .out_valid         (out_valid),
    .out_data          (out_data)
  );

`ifndef SYNTH
  a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.last && out_data.status != ST_OK)
    else $error("rejected item result is not final or carries ok status");

  a_point_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res |-> out_data.status == ST_OK)
    else $error("guide point carries an error status");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result follows the final result of an item without a gap");
`endif

endmodule

>>> verif/tb_turn_fillet_guide_points.sv
// Self-checking testbench for turn_fillet_guide_points with a scoreboard and random turns.
`timescale 1ns / 1ps

module tb_turn_fillet_guide_points;
  import tfgp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint ARC_STEP [30] = '{
    536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  class fillet_scoreboard;
    longint unsigned min_defl, max_defl, spacing, len_tol;
    tfgp_out_t guide_q[$];
    int errors;

    function new();
      min_defl = 1820;
      max_defl = 30948;
      spacing = 32768;
      len_tol = 66;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_MIN_DEFL: min_defl = val[15:0];
        REG_MAX_DEFL: max_defl = val[15:0];
        REG_SPACING:  spacing = val[30:0];
        REG_LEN_TOL:  len_tol = val[15:0];
        default: ;
      endcase
    endfunction

    function void add_expected(tfgp_out_t r);
      guide_q.insert(guide_q.size(), r);
    endfunction

    function void unit_vector(bit [31:0] ang, output longint c, output longint s);
      bit [31:0] sh;
      longint x, y, z, nx;
      sh = ang + 32'h2000_0000;
      z = longint'({34'd0, sh[29:0]}) - 64'sd536870912;
      x = 652032875;
      y = 0;
      if (z == 0) begin
        x = 64'sd1 << 30;
      end else begin
        for (int i = 0; i < 30; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - ARC_STEP[i];
          end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + ARC_STEP[i];
          end
          x = nx;
        end
      end
      case (sh[31:30])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      c = (c + 2) >>> 2;
      s = (s + 2) >>> 2;
    endfunction

    function longint scale(longint len, longint f);
      return (len * f + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function longint clamp_len(longint v);
      longint lim;
      lim = 64'sd1 <<< 33;
      return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function tfgp_out_t make_point(longint x, longint y, logic [15:0] hdg);
      tfgp_out_t r;
      r.point_x = sat32(x);
      r.point_y = sat32(y);
      r.point_heading = hdg;
      r.valid_res = 1'b1;
      r.status = ST_OK;
      r.last = 1'b0;
      return r;
    endfunction

    function void reject(logic [2:0] st);
      tfgp_out_t r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      add_expected(r);
    endfunction

    function void note_item(tfgp_in_t it);
      logic [15:0] ha, hb, dwrap;
      longint delta, defl, cd, det, c1, s1, c2, s2, rx, ry, t, u, leg, cx, cy;
      longint cq, sq, tanq, reach, bc, bs;
      bit [31:0] m32, b32, hr, qa;
      tfgp_out_t pts[3];
      int k;
      ha = it.start_heading;
      hb = it.end_heading;
      dwrap = hb - ha;
      delta = longint'(signed'(dwrap));
      defl = delta < 0 ? -delta : delta;
      k = 0;
      if (defl < longint'(min_defl) || defl > longint'(max_defl)) begin
        reject(ST_BAND);
        return;
      end
      unit_vector({dwrap, 16'h0}, cd, det);
      if (det == 0) begin
        reject(ST_PARALLEL);
        return;
      end
      unit_vector({ha, 16'h0}, c1, s1);
      unit_vector({hb, 16'h0}, c2, s2);
      rx = longint'(it.end_x) - longint'(it.start_x);
      ry = longint'(it.end_y) - longint'(it.start_y);
      t = clamp_len((rx * s2 - ry * c2) / det);
      u = clamp_len((ry * c1 - rx * s1) / det);
      if (t <= longint'(len_tol) || u <= longint'(len_tol)) begin
        reject(ST_BEHIND);
        return;
      end
      cx = longint'(it.start_x) + scale(t, c1);
      cy = longint'(it.start_y) + scale(t, s1);
      leg = t < u ? t : u;
      qa = {defl[15:0], 16'h0};
      unit_vector(qa >> 2, cq, sq);
      tanq = (sq * (64'sd1 <<< 28)) / cq;
      reach = scale(leg, tanq);
      m32 = {ha, 16'h0} + 32'((delta * 65536) / 2);
      b32 = m32 + (delta > 0 ? 32'h4000_0000 : 32'hC000_0000);
      unit_vector(b32, bc, bs);
      hr = m32 + 32'h8000;
      if (t - leg > longint'(spacing)) begin
        pts[k] = make_point(cx - scale(leg, c1), cy - scale(leg, s1), ha);
        k++;
      end
      pts[k] = make_point(cx + scale(reach, bc), cy + scale(reach, bs), hr[31:16]);
      k++;
      if (u - leg > longint'(spacing)) begin
        pts[k] = make_point(cx + scale(leg, c2), cy + scale(leg, s2), hb);
        k++;
      end
      pts[k-1].last = 1'b1;
      for (int i = 0; i < k; i++) add_expected(pts[i]);
    endfunction

    function void check_point(tfgp_out_t got);
      tfgp_out_t exp_p;
      if (guide_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_p = guide_q.pop_front();
      if (got.point_x !== exp_p.point_x) begin
        $error("point_x expected %0d got %0d", exp_p.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== exp_p.point_y) begin
        $error("point_y expected %0d got %0d", exp_p.point_y, got.point_y);
        errors++;
      end
      if (got.point_heading !== exp_p.point_heading) begin
        $error("point_heading expected %0d got %0d", exp_p.point_heading, got.point_heading);
        errors++;
      end
      if (got.valid_res !== exp_p.valid_res) begin
        $error("valid_res expected %0d got %0d", exp_p.valid_res, got.valid_res);
        errors++;
      end
      if (got.status !== exp_p.status) begin
        $error("status expected %0d got %0d", exp_p.status, got.status);
        errors++;
      end
      if (got.last !== exp_p.last) begin
        $error("last expected %0d got %0d", exp_p.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tfgp_in_t in_data = '0;
  logic out_valid;
  tfgp_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MIN_DEFL;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int stall_cycles = 0;
  bit idling = 1'b1;
  fillet_scoreboard sb = new();

  turn_fillet_guide_points i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_point(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_turn_fillet_guide_points: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic signed [31:0] to_q16(real m);
    real v;
    v = m * 65536.0;
    if (v > 2147483647.0) v = 2147483647.0;
    if (v < -2147483648.0) v = -2147483648.0;
    return 32'(longint'(v));
  endfunction

  // Builds a turn whose legs meet at a corner t metres ahead of the start point
  // and u metres behind the end point.
  function automatic tfgp_in_t make_turn(real ax, real ay, logic [15:0] ha,
                                         longint delta, real t, real u);
    tfgp_in_t it;
    real a1, a2, cx, cy;
    it.start_heading = ha;
    it.end_heading = ha + 16'(delta);
    a1 = ha * 6.283185307179586 / 65536.0;
    a2 = it.end_heading * 6.283185307179586 / 65536.0;
    cx = ax + t * $cos(a1);
    cy = ay + t * $sin(a1);
    it.start_x = to_q16(ax);
    it.start_y = to_q16(ay);
    it.end_x = to_q16(cx + u * $cos(a2));
    it.end_y = to_q16(cy + u * $sin(a2));
    return it;
  endfunction

  function automatic tfgp_in_t random_turn();
    tfgp_in_t it;
    int sel;
    longint delta;
    real t, u;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      it.start_x = $urandom;
      it.start_y = $urandom;
      it.start_heading = 16'($urandom);
      it.end_x = $urandom;
      it.end_y = $urandom;
      it.end_heading = 16'($urandom);
      return it;
    end
    delta = $urandom_range(1, 32767);
    if (sel < 80) delta = $urandom_range(1820, 30948);
    if ($urandom_range(0, 1)) delta = -delta;
    t = $urandom_range(1, 3000) + $urandom_range(0, 65535) / 65536.0;
    u = $urandom_range(0, 3) == 0 ? t : $urandom_range(1, 3000) + 0.25;
    if ($urandom_range(0, 7) == 0) t = $urandom_range(0, 100) / 65536.0;
    if (sel >= 88) u = -u;
    return make_turn($urandom_range(0, 16000) - 8000.0, $urandom_range(0, 16000) - 8000.0,
                     16'($urandom), delta, t, u);
  endfunction

  task automatic send_item(tfgp_in_t it);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.guide_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(logic [CFG_W-1:0] mn, logic [CFG_W-1:0] mx,
                            logic [CFG_W-1:0] sp, logic [CFG_W-1:0] tol);
    logic [CFG_W-1:0] vals [4];
    vals = '{mn, mx, sp, tol};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(2'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_item(random_turn());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item('0);
    send_item('1);
    send_item({32'h8000_0000, 32'h8000_0000, 16'h0, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff});
    send_item(make_turn(0.0, 0.0, 16'h0, 1820, 100.0, 100.0));
    send_item(make_turn(0.0, 0.0, 16'h1000, 1819, 100.0, 100.0));
    send_item(make_turn(0.0, 0.0, 16'h2000, -30948, 100.0, 100.0));
    send_item(make_turn(0.0, 0.0, 16'h3000, 30949, 100.0, 100.0));
    send_item(make_turn(10.0, -5.0, 16'd16384, 16384, 200.0, 50.0));
    send_item(make_turn(-10.0, 5.0, 16'd60000, -9000, 50.0, 200.0));
    send_item(make_turn(3.5, 7.25, 16'd65535, 8000, 80.0, 80.0));
    send_item(make_turn(0.0, 0.0, 16'd4000, 12000, -40.0, 60.0));
    send_item(make_turn(0.0, 0.0, 16'd4000, 12000, 60.0, -40.0));
    send_item(make_turn(0.0, 0.0, 16'd100, 5000, 0.0005, 30.0));
    send_item(make_turn(30000.0, 30000.0, 16'd8192, 20000, 5000.0, 20000.0));
    send_item(make_turn(-32000.0, 100.0, 16'd32768, -2000, 9000.0, 40000.0));
    drain();
    random_run(70);

    write_regs(31'h7fff_0000, 31'h5555_8000, 31'd0, 31'h2aaa_0000);
    send_item(make_turn(1.0, 2.0, 16'd500, 0, 10.0, 10.0));
    send_item(make_turn(1.0, 2.0, 16'd500, -32768, 10.0, 10.0));
    send_item({32'h0, 32'h0, 16'd0, 32'h0, 32'h0, 16'd32768});
    send_item(make_turn(0.0, 0.0, 16'd0, 1, 30000.0, 30000.0));
    send_item(make_turn(0.0, 0.0, 16'd777, 32767, 5.0, 7.0));
    send_item(make_turn(0.0, 0.0, 16'd777, 3000, 1.0 / 65536.0, 7.0));
    drain();
    random_run(70);

    write_regs(31'd32768, 31'd0, 31'h7fff_ffff, 31'd65535);
    random_run(20);

    write_regs(31'($urandom_range(0, 3000)), 31'($urandom_range(28000, 32768)),
               31'($urandom_range(0, 2000000)), 31'($urandom_range(0, 65535)));
    random_run(50);

    write_regs(31'd1820, 31'd30948, 31'd32768, 31'd66);
    idling = 1'b0;
    random_run(50);

    if (sb.errors == 0) begin
      $display("tb_turn_fillet_guide_points: clean");
    end else begin
      $display("tb_turn_fillet_guide_points: errors");
    end
    $finish;
  end

endmodule
